>>> src/tcg_pkg.sv
package tcg_pkg;

  // Action codes of a request
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_FG   = 2'd0;
  localparam logic [1:0] REG_BG   = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;
  localparam logic [1:0] REG_ROWS = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam logic [31:0] FG_RST    = 32'hFFFF_FFFF;
  localparam logic [31:0] BG_RST    = 32'hFF00_0000;
  localparam logic [31:0] COLOUR_NONE = 32'h0000_0000;
  localparam logic [7:0]  COLS_RST  = 8'd80;
  localparam logic [6:0]  ROWS_RST  = 7'd25;

  typedef struct packed {
    logic [7:0]  ch;
    logic [31:0] fg;
    logic [31:0] bg;
  } tcg_cell_t;

  typedef struct packed {
    logic ch;
    logic fg;
    logic bg;
  } tcg_we_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic [7:0]  cell_char;
    logic [31:0] cell_fg;
    logic [31:0] cell_bg;
    logic        scrolled;
  } tcg_res_t;

endpackage

>>> src/text_console_grid_with_scroll_unit.sv
// Channel   Handshake                        Payload
// -------   ------------------------------   ----------------------------------------------
// request   req_valid / req_ready            action, char_code, read_col, read_row
// result    rsp_valid / rsp_ready            cursor_col, cursor_row, cell_char, cell_fg,
//                                            cell_bg, scrolled
// config    APB psel/penable/pwrite/pready   paddr[3:2] register, pwdata / prdata
//
// Write, new line without scroll and delete finish in the accepting cycle; a read inside
// the grid waits in ST_RDWAIT for the registered cell memory read. Clear sweeps all
// MAX_COLS*MAX_ROWS cells after the accepting cycle, one cell per cycle through the
// single write port. A scroll moves each cell in use of rows 1 to rows-1 up a row
// through the memory read port and back through the write port, then blanks the bottom
// row; with a single row only the blanking runs. After reset a fill pass loads all
// MAX_COLS*MAX_ROWS cells (8192 by default) with their reset contents; no request is
// taken meanwhile, register writes are. A result sits in an output register; the next
// request is taken while it waits only if rsp_ready drains it in the same cycle.
module text_console_grid_with_scroll_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  char_code,
  input  logic [6:0]  read_col,
  input  logic [5:0]  read_row,

  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [6:0]  cursor_col,
  output logic [5:0]  cursor_row,
  output logic [7:0]  cell_char,
  output logic [31:0] cell_fg,
  output logic [31:0] cell_bg,
  output logic        scrolled
);

  import tcg_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [31:0] fg_colour;
  logic [31:0] bg_colour;
  logic [7:0]  cols_in_use;
  logic [6:0]  rows_in_use;
  logic        cfg_wr;

  // Sequencer <-> memory and address unit
  logic [$clog2(MAX_ROWS)-1:0] addr_row;
  logic [$clog2(MAX_COLS)-1:0] addr_col;
  logic [AW-1:0]               addr;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               waddr;
  tcg_we_t                     we;
  tcg_cell_t                   wdata;
  tcg_cell_t                   rdata;
  logic [7:0]                  rd_ch;
  logic [31:0]                 rd_fg;
  logic [31:0]                 rd_bg;

  // Result hand-off
  logic     res_free;
  logic     res_load;
  tcg_res_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write a register at the access phase of an APB write
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_colour   <= FG_RST;
      bg_colour   <= BG_RST;
      cols_in_use <= COLS_RST;
      rows_in_use <= ROWS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FG:   fg_colour   <= pwdata;
        REG_BG:   bg_colour   <= pwdata;
        REG_COLS: cols_in_use <= pwdata[7:0];
        REG_ROWS: rows_in_use <= pwdata[6:0];
        default:  fg_colour   <= fg_colour;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[3:2])
      REG_FG:   prdata = fg_colour;
      REG_BG:   prdata = bg_colour;
      REG_COLS: prdata = {24'd0, cols_in_use};
      REG_ROWS: prdata = {25'd0, rows_in_use};
      default:  prdata = 32'd0;
    endcase
  end

  // Shared cell address unit: row * MAX_COLS + col; the init and clear sweeps bypass it
  tcg_addr #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_addr (
    .row  (addr_row),
    .col  (addr_col),
    .addr (addr)
  );

  tcg_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .action    (action),
    .char_code (char_code),
    .read_col  (read_col),
    .read_row  (read_row),
    .cfg_fg    (fg_colour),
    .cfg_bg    (bg_colour),
    .cfg_cols  (cols_in_use),
    .cfg_rows  (rows_in_use),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .addr_row  (addr_row),
    .addr_col  (addr_col),
    .addr      (addr),
    .raddr     (raddr),
    .waddr     (waddr),
    .we        (we),
    .wdata     (wdata),
    .rdata     (rdata)
  );

  // Cell store: separate planes so a scroll can blank a row and keep its foreground
  tcg_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram_char (
    .clk   (clk),
    .we    (we.ch),
    .waddr (waddr),
    .wdata (wdata.ch),
    .raddr (raddr),
    .rdata (rd_ch)
  );

  tcg_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram_fg (
    .clk   (clk),
    .we    (we.fg),
    .waddr (waddr),
    .wdata (wdata.fg),
    .raddr (raddr),
    .rdata (rd_fg)
  );

  tcg_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram_bg (
    .clk   (clk),
    .we    (we.bg),
    .waddr (waddr),
    .wdata (wdata.bg),
    .raddr (raddr),
    .rdata (rd_bg)
  );

  assign rdata = '{ch: rd_ch, fg: rd_fg, bg: rd_bg};

  // Output register: free when empty or drained by this transfer
  assign res_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold the payload until the transfer; load only when a result completes
  always_ff @(posedge clk) begin
    if (res_load) begin
      cursor_col <= res.cursor_col;
      cursor_row <= res.cursor_row;
      cell_char  <= res.cell_char;
      cell_fg    <= res.cell_fg;
      cell_bg    <= res.cell_bg;
      scrolled   <= res.scrolled;
    end
  end

endmodule

>>> src/tcg_ram.sv
module tcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tcg_addr.sv
module tcg_addr #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic [$clog2(MAX_ROWS)-1:0]          row,
  input  logic [$clog2(MAX_COLS)-1:0]          col,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] addr
);

  localparam int AW = $clog2(MAX_COLS * MAX_ROWS);

  // Row-major cell address: row * MAX_COLS + col
  assign addr = AW'(AW'(row) * AW'(MAX_COLS)) + AW'(col);

endmodule

>>> src/tcg_seq.sv
module tcg_seq #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [1:0]                           action,
  input  logic [7:0]                           char_code,
  input  logic [6:0]                           read_col,
  input  logic [5:0]                           read_row,
  input  logic [31:0]                          cfg_fg,
  input  logic [31:0]                          cfg_bg,
  input  logic [7:0]                           cfg_cols,
  input  logic [6:0]                           cfg_rows,
  input  logic                                 res_free,
  output logic                                 res_load,
  output tcg_pkg::tcg_res_t                    res,
  output logic [$clog2(MAX_ROWS)-1:0]          addr_row,
  output logic [$clog2(MAX_COLS)-1:0]          addr_col,
  input  logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] addr,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] raddr,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] waddr,
  output tcg_pkg::tcg_we_t                     we,
  output tcg_pkg::tcg_cell_t                   wdata,
  input  tcg_pkg::tcg_cell_t                   rdata
);

  import tcg_pkg::*;

  localparam int CIW   = $clog2(MAX_COLS);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_COPY   = 3'd4;
  localparam logic [2:0] ST_BLANK  = 3'd5;

  logic [2:0]     state, state_next;
  logic [AW-1:0]  sweep, sweep_next;
  logic [CIW-1:0] scol, scol_next;
  logic [RIW-1:0] srow, srow_next;
  logic           cp_pend, cp_pend_next;
  logic [AW-1:0]  cp_waddr, cp_waddr_next;
  logic [CIW-1:0] cur_col, cur_col_next;
  logic [RIW-1:0] cur_row, cur_row_next;

  logic [8:0]     cols9;
  logic [7:0]     rows8;
  logic [CNW-1:0] cols;
  logic [RNW-1:0] rows;
  logic [CIW-1:0] cc, dl_col, wr_col_n;
  logic [RIW-1:0] cr, dl_row, wr_row_n;
  logic [CNW-1:0] col_inc;
  logic [RNW-1:0] row_inc;
  logic           is_nl, go_next, at_bottom, wr_scroll, at_home, rd_in;
  logic           last_col, last_row, accept;

  // Grid size clamped to the stored range
  always_comb begin
    if (cfg_cols == 8'd0) begin
      cols9 = 9'd1;
    end else if ({1'b0, cfg_cols} > 9'(MAX_COLS)) begin
      cols9 = 9'(MAX_COLS);
    end else begin
      cols9 = {1'b0, cfg_cols};
    end
    if (cfg_rows == 7'd0) begin
      rows8 = 8'd1;
    end else if ({1'b0, cfg_rows} > 8'(MAX_ROWS)) begin
      rows8 = 8'(MAX_ROWS);
    end else begin
      rows8 = {1'b0, cfg_rows};
    end
  end

  assign cols = CNW'(cols9);
  assign rows = RNW'(rows8);

  assign cc = (CNW'(cur_col) >= cols) ? CIW'(cols - CNW'(1)) : cur_col;
  assign cr = (RNW'(cur_row) >= rows) ? RIW'(rows - RNW'(1)) : cur_row;

  // Character write and new line
  assign col_inc   = CNW'(cc) + CNW'(1);
  assign row_inc   = RNW'(cr) + RNW'(1);
  assign is_nl     = (char_code == CH_LF) || (char_code == CH_CR);
  assign go_next   = is_nl || (col_inc >= cols);
  assign at_bottom = row_inc >= rows;
  assign wr_scroll = go_next && at_bottom;
  assign wr_col_n  = go_next ? '0 : CIW'(col_inc);
  assign wr_row_n  = (go_next && !at_bottom) ? RIW'(row_inc) : cr;

  // Delete back
  assign at_home = (cc == '0) && (cr == '0);
  assign dl_col  = (cc == '0) ? CIW'(cols - CNW'(1)) : cc - CIW'(1);
  assign dl_row  = (cc == '0) ? cr - RIW'(1) : cr;

  assign rd_in = (9'(read_col) < cols9) && (8'(read_row) < rows8);

  assign last_col = CNW'(scol) == (cols - CNW'(1));
  assign last_row = (RNW'(srow) + RNW'(1)) == (rows - RNW'(1));

  assign req_ready = (state == ST_IDLE) && res_free;
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next    = state;
    sweep_next    = sweep;
    scol_next     = scol;
    srow_next     = srow;
    cp_pend_next  = 1'b0;
    cp_waddr_next = cp_waddr;
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    addr_row      = '0;
    addr_col      = '0;
    raddr         = addr;
    waddr         = addr;
    we            = '0;
    wdata         = '{ch: CH_SPACE, fg: cfg_fg, bg: cfg_bg};
    res_load      = 1'b0;
    res           = '{cursor_col: 7'(cur_col), cursor_row: 6'(cur_row),
                      cell_char: 8'd0, cell_fg: COLOUR_NONE, cell_bg: COLOUR_NONE,
                      scrolled: 1'b0};

    case (state)
      ST_INIT: begin
        waddr = sweep;
        we    = '{ch: 1'b1, fg: 1'b1, bg: 1'b1};
        wdata = '{ch: CH_SPACE, fg: FG_RST, bg: BG_RST};
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(DEPTH - 1)) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        waddr = sweep;
        we    = '{ch: 1'b1, fg: 1'b1, bg: 1'b1};
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(DEPTH - 1)) begin
          sweep_next = '0;
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        case (action)
          ACT_WRITE: begin
            addr_row = cr;
            addr_col = cc;
          end
          ACT_DELETE: begin
            addr_row = dl_row;
            addr_col = dl_col;
          end
          ACT_READ: begin
            addr_row = RIW'(read_row);
            addr_col = CIW'(read_col);
          end
          default: begin
            addr_row = '0;
            addr_col = '0;
          end
        endcase

        if (accept) begin
          case (action)
            ACT_WRITE: begin
              if (!is_nl) begin
                we    = '{ch: 1'b1, fg: 1'b1, bg: 1'b1};
                wdata = '{ch: char_code, fg: cfg_fg, bg: cfg_bg};
              end
              cur_col_next = wr_col_n;
              cur_row_next = wr_row_n;
              if (wr_scroll) begin
                scol_next  = '0;
                srow_next  = '0;
                state_next = (rows > RNW'(1)) ? ST_COPY : ST_BLANK;
              end else begin
                res_load = 1'b1;
                res.cursor_col = 7'(wr_col_n);
                res.cursor_row = 6'(wr_row_n);
              end
            end
            ACT_DELETE: begin
              res_load = 1'b1;
              if (at_home) begin
                cur_col_next = cc;
                cur_row_next = cr;
                res.cursor_col = 7'(cc);
                res.cursor_row = 6'(cr);
              end else begin
                we    = '{ch: 1'b1, fg: 1'b1, bg: 1'b1};
                wdata = '{ch: CH_SPACE, fg: COLOUR_NONE, bg: COLOUR_NONE};
                cur_col_next = dl_col;
                cur_row_next = dl_row;
                res.cursor_col = 7'(dl_col);
                res.cursor_row = 6'(dl_row);
              end
            end
            ACT_CLEAR: begin
              cur_col_next = '0;
              cur_row_next = '0;
              sweep_next   = '0;
              state_next   = ST_CLEAR;
            end
            ACT_READ: begin
              cur_col_next = cc;
              cur_row_next = cr;
              if (rd_in) begin
                state_next = ST_RDWAIT;
              end else begin
                res_load = 1'b1;
                res.cursor_col = 7'(cc);
                res.cursor_row = 6'(cr);
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_RDWAIT: begin
        res_load       = 1'b1;
        res.cell_char  = rdata.ch;
        res.cell_fg    = rdata.fg;
        res.cell_bg    = rdata.bg;
        state_next     = ST_IDLE;
      end

      ST_COPY: begin
        // Read the source cell one row down, write it into the row above in the next cycle
        addr_row      = srow + RIW'(1);
        addr_col      = scol;
        cp_pend_next  = 1'b1;
        cp_waddr_next = addr - AW'(MAX_COLS);
        if (cp_pend) begin
          waddr = cp_waddr;
          we    = '{ch: 1'b1, fg: 1'b1, bg: 1'b1};
          wdata = rdata;
        end
        if (last_col) begin
          scol_next = '0;
          if (last_row) begin
            state_next = ST_BLANK;
          end else begin
            srow_next = srow + RIW'(1);
          end
        end else begin
          scol_next = scol + CIW'(1);
        end
      end

      ST_BLANK: begin
        if (cp_pend) begin
          waddr = cp_waddr;
          we    = '{ch: 1'b1, fg: 1'b1, bg: 1'b1};
          wdata = rdata;
        end else begin
          // Bottom row: space and background, foreground kept
          addr_row = RIW'(rows - RNW'(1));
          addr_col = scol;
          we       = '{ch: 1'b1, fg: 1'b0, bg: 1'b1};
          if (last_col) begin
            scol_next    = '0;
            res_load     = 1'b1;
            res.scrolled = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            scol_next = scol + CIW'(1);
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      sweep   <= '0;
      scol    <= '0;
      srow    <= '0;
      cp_pend <= 1'b0;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      state   <= state_next;
      sweep   <= sweep_next;
      scol    <= scol_next;
      srow    <= srow_next;
      cp_pend <= cp_pend_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end

  always_ff @(posedge clk) begin
    cp_waddr <= cp_waddr_next;
  end

endmodule
